FILE: rtl/pmq_pkg.sv
// ----------------------------------------------------------------------------
// pmq_pkg
// Shared types, constants and helpers for the priority message queue.
// ----------------------------------------------------------------------------
package pmq_pkg;

    localparam int DEPTH         = 16;
    localparam int SLOT_W        = $clog2(DEPTH);
    localparam int LEVELS        = 8;
    localparam int PRIO_W        = $clog2(LEVELS);
    localparam int PAYLOAD_BYTES = 8;
    localparam int DATA_W        = 8 * PAYLOAD_BYTES;
    localparam int REQ_LEN_W     = 8;
    localparam int LEN_W         = 4;
    localparam int CNT_W         = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 5;
    localparam int S_TDATA_W     = 80;
    localparam int M_TDATA_W     = 80;

    localparam logic [1:0] ACC_RDONLY = 2'd0;
    localparam logic [1:0] ACC_WRONLY = 2'd1;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_BADF  = 3'd1,
        ST_SIZE  = 3'd2,
        ST_AGAIN = 3'd3,
        ST_BLOCK = 3'd4
    } t_status;

    typedef enum logic {
        CMD_SEND = 1'b0,
        CMD_RECV = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCESS    = 2'd0,
        CFG_NONBLOCK  = 2'd1,
        CFG_MAX_MSGS  = 2'd2,
        CFG_MAX_BYTES = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic    load_in;
        logic    load_out;
        logic    do_send;
        logic    do_recv;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        logic is_recv;
        logic acc_ok;
        logic size_ok;
        logic room_ok;
        logic nonblocking;
    } t_dp_stat;

    function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] nbytes);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < PAYLOAD_BYTES; b++) begin
            if (LEN_W'(b) < nbytes) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

FILE: rtl/pmq_ctrl.sv
// ----------------------------------------------------------------------------
// pmq_ctrl
// Request sequencer: takes a request, issues one execute step when the
// result register is free, and tracks the result valid flag.
// ----------------------------------------------------------------------------
module pmq_ctrl
    import pmq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    output logic     o_m_tvalid,
    input  logic     i_m_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    logic    out_free;
    t_status code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        priority if (!i_stat.acc_ok) begin
            code = ST_BADF;
        end else if (!i_stat.size_ok) begin
            code = ST_SIZE;
        end else if (!i_stat.room_ok) begin
            code = i_stat.nonblocking ? ST_AGAIN : ST_BLOCK;
        end else begin
            code = ST_OK;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.code     = code;
                    o_cmd.do_send  = (code == ST_OK) && !i_stat.is_recv;
                    o_cmd.do_recv  = (code == ST_OK) && i_stat.is_recv;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.load_out || (r_out_valid && !i_m_tready);
    end

    assign o_m_tvalid = r_out_valid;

endmodule

FILE: rtl/pmq_dp.sv
// ----------------------------------------------------------------------------
// pmq_dp
// Datapath: configuration registers, request latch, slot pool with free
// list and per-level FIFO links, message store and result register.
// ----------------------------------------------------------------------------
module pmq_dp
    import pmq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_op,
    input  logic [DATA_W-1:0]     i_payload,
    input  logic [REQ_LEN_W-1:0]  i_length,
    input  logic [PRIO_W-1:0]     i_priority,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic [2:0]            o_status,
    output logic [DATA_W-1:0]     o_data,
    output logic [LEN_W-1:0]      o_length,
    output logic [PRIO_W-1:0]     o_priority,
    output logic                  o_wake,
    output logic [CNT_W-1:0]      o_count
);

    logic [1:0]       r_access_mode;
    logic             r_nonblocking;
    logic [CNT_W-1:0] r_max_msgs;
    logic [LEN_W-1:0] r_max_bytes;

    t_op                  r_op;
    logic [DATA_W-1:0]    r_payload;
    logic [REQ_LEN_W-1:0] r_len;
    logic [PRIO_W-1:0]    r_prio;

    logic [SLOT_W-1:0] r_next_link [DEPTH];
    logic [SLOT_W-1:0] r_level_head [LEVELS];
    logic [SLOT_W-1:0] r_level_tail [LEVELS];
    logic [LEVELS-1:0] r_level_nonempty;
    logic [SLOT_W-1:0] r_free_head;
    logic [CNT_W-1:0]  r_held_count;

    logic [DATA_W-1:0] r_payload_mem [DEPTH];
    logic [LEN_W-1:0]  r_length_mem [DEPTH];

    logic [DATA_W-1:0] r_rd_data;
    logic [LEN_W-1:0]  r_rd_len;
    logic [PRIO_W-1:0] r_prio_out;
    t_status           r_status;

    logic              can_read, can_write;
    logic [LEN_W-1:0]  limit;
    logic [CNT_W-1:0]  cap;
    logic [PRIO_W-1:0] top_level;
    logic [SLOT_W-1:0] rx_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_access_mode <= 2'd2;
            r_nonblocking <= 1'b1;
            r_max_msgs    <= CNT_W'(DEPTH);
            r_max_bytes   <= LEN_W'(PAYLOAD_BYTES);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ACCESS:    r_access_mode <= i_cfg_data[1:0];
                CFG_NONBLOCK:  r_nonblocking <= i_cfg_data[0];
                CFG_MAX_MSGS:  r_max_msgs    <= i_cfg_data[CNT_W-1:0];
                CFG_MAX_BYTES: r_max_bytes   <= i_cfg_data[LEN_W-1:0];
                default:       r_access_mode <= r_access_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op      <= t_op'(i_op);
            r_payload <= i_payload;
            r_len     <= i_length;
            r_prio    <= i_priority;
        end
    end

    assign can_read  = (r_access_mode == ACC_RDONLY) || r_access_mode[1];
    assign can_write = (r_access_mode == ACC_WRONLY) || r_access_mode[1];
    assign limit     = (r_max_bytes > LEN_W'(PAYLOAD_BYTES)) ? LEN_W'(PAYLOAD_BYTES)
                                                             : r_max_bytes;
    assign cap       = (r_max_msgs > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : r_max_msgs;

    always_comb begin
        top_level = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (r_level_nonempty[i]) begin
                top_level = PRIO_W'(i);
            end
        end
    end

    assign rx_slot = r_level_head[top_level];

    always_comb begin
        o_stat.is_recv     = (r_op == CMD_RECV);
        o_stat.nonblocking = r_nonblocking;
        if (r_op == CMD_RECV) begin
            o_stat.acc_ok  = can_read;
            o_stat.size_ok = r_len >= REQ_LEN_W'(limit);
            o_stat.room_ok = (r_held_count != '0) && (r_level_nonempty != '0);
        end else begin
            o_stat.acc_ok  = can_write;
            o_stat.size_ok = r_len <= REQ_LEN_W'(limit);
            o_stat.room_ok = (r_held_count < cap) && (r_held_count < CNT_W'(DEPTH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_next_link[i] <= SLOT_W'(i + 1);
            end
            for (int i = 0; i < LEVELS; i++) begin
                r_level_head[i] <= '0;
                r_level_tail[i] <= '0;
            end
            r_level_nonempty <= '0;
            r_free_head      <= '0;
            r_held_count     <= '0;
        end else if (i_cmd.do_send) begin
            r_free_head <= r_next_link[r_free_head];
            if (r_level_nonempty[r_prio]) begin
                r_next_link[r_level_tail[r_prio]] <= r_free_head;
            end else begin
                r_level_head[r_prio]     <= r_free_head;
                r_level_nonempty[r_prio] <= 1'b1;
            end
            r_level_tail[r_prio] <= r_free_head;
            r_held_count         <= r_held_count + CNT_W'(1);
        end else if (i_cmd.do_recv) begin
            if (rx_slot == r_level_tail[top_level]) begin
                r_level_nonempty[top_level] <= 1'b0;
            end else begin
                r_level_head[top_level] <= r_next_link[rx_slot];
            end
            r_next_link[rx_slot] <= r_free_head;
            r_free_head          <= rx_slot;
            r_held_count         <= r_held_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_send) begin
            r_payload_mem[r_free_head] <= r_payload & byte_mask(r_len[LEN_W-1:0]);
            r_length_mem[r_free_head]  <= r_len[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status <= i_cmd.code;
            if (i_cmd.do_recv) begin
                r_rd_data  <= r_payload_mem[rx_slot];
                r_rd_len   <= r_length_mem[rx_slot];
                r_prio_out <= top_level;
            end else begin
                r_rd_data  <= '0;
                r_rd_len   <= '0;
                r_prio_out <= '0;
            end
        end
    end

    assign o_status   = r_status;
    assign o_data     = r_rd_data;
    assign o_length   = r_rd_len;
    assign o_priority = r_prio_out;
    assign o_wake     = (r_status == ST_OK);
    assign o_count    = r_held_count;

endmodule

FILE: rtl/priority_message_queue.sv
// A request taken on s_axis is latched in the request register; the execute step then loads
// the result register on m_axis once it is free. The sequencer alternates take and execute,
// taking no new request before the execute step, which does the slot-list read-modify-write.
// A waiting result holds; the next request is taken but executes once that result is taken.
// Reset (synchronous, active low): free list chained in slot order, all levels empty,
// configuration back to read/write, nonblocking, 16 messages of 8 bytes.
// ----------------------------------------------------------------------------
// priority_message_queue
// Priority message queue with one FIFO per level over a shared slot pool.
// ----------------------------------------------------------------------------
module priority_message_queue
    import pmq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // payload[63:0], length[71:64], priority_req[74:72], zero pad[79:75]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // cmd[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[2:0], data_out[66:3], length_out[70:67], priority_out[73:71],
    // wake_peer[74], message_count[79:75]
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    logic [2:0]        res_status;
    logic [DATA_W-1:0] res_data;
    logic [LEN_W-1:0]  res_length;
    logic [PRIO_W-1:0] res_priority;
    logic              res_wake;
    logic [CNT_W-1:0]  res_count;

    assign o_cfg_ready = 1'b1;

    pmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pmq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (s_axis_tuser),
        .i_payload   (s_axis_tdata[DATA_W-1:0]),
        .i_length    (s_axis_tdata[DATA_W +: REQ_LEN_W]),
        .i_priority  (s_axis_tdata[DATA_W+REQ_LEN_W +: PRIO_W]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_status    (res_status),
        .o_data      (res_data),
        .o_length    (res_length),
        .o_priority  (res_priority),
        .o_wake      (res_wake),
        .o_count     (res_count)
    );

    assign m_axis_tdata = {res_count, res_wake, res_priority, res_length, res_data,
                           res_status};

endmodule

FILE: rtl/pmq_checker.sv
// ----------------------------------------------------------------------------
// pmq_checker
// Port-level checks on the result stream of the priority message queue.
// ----------------------------------------------------------------------------
module pmq_checker
    import pmq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[74] == (m_axis_tdata[2:0] == ST_OK))
        else $error("wake flag disagrees with status");

    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |->
            m_axis_tdata[66:3] == '0 && m_axis_tdata[70:67] == '0
            && m_axis_tdata[73:71] == '0)
        else $error("failed request returned message data");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[79:75] <= CNT_W'(DEPTH))
        else $error("message count above pool size");

endmodule

bind priority_message_queue pmq_checker u_pmq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/tb_priority_message_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_message_queue
// Self-checking bench for the priority message queue. An opening table walks
// the error codes, the register extremes and FIFO order within a level. Random
// phases follow, each with fresh register values. Untyped results are compared
// field by field with a cycle-free model of the slot pool and level lists.
// ----------------------------------------------------------------------------
module tb_priority_message_queue;
    import pmq_pkg::*;

    localparam logic [1:0] ACC_RDWR     = 2'd2;
    localparam logic [1:0] ACC_RDWR_ALT = 2'd3;
    localparam int         N_OPENING    = 37;
    localparam int         N_PHASES     = 14;
    localparam int         PHASE_ITEMS  = 125;
    localparam int         MAX_REPORTS  = 10;
    localparam int         CYCLE_LIMIT  = 500000;

    typedef enum logic {
        ROW_REQ = 1'b0,
        ROW_CFG = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_status         status;
        logic [63:0]     data;
        logic [LEN_W-1:0] len;
        logic [PRIO_W-1:0] prio;
        logic            wake;
        logic [CNT_W-1:0] count;
    } msg_result_t;

    typedef struct packed {
        t_row_kind             kind;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_op                   op;
        logic [REQ_LEN_W-1:0]  len;
        logic [PRIO_W-1:0]     prio;
        logic                  typed;
        t_status               want_status;
        logic [CNT_W-1:0]      want_count;
        logic [DATA_W-1:0]     payload;
    } step_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    // queue model state
    logic [DATA_W-1:0]  slot_payload [DEPTH];
    logic [LEN_W-1:0]   slot_len     [DEPTH];
    logic [SLOT_W-1:0]  slot_next    [DEPTH];
    logic [SLOT_W-1:0]  lvl_head     [LEVELS];
    logic [SLOT_W-1:0]  lvl_tail     [LEVELS];
    logic [LEVELS-1:0]  lvl_busy;
    logic [SLOT_W-1:0]  free_slot;
    int unsigned        held;
    logic [1:0]         q_access;
    logic               q_nonblock;
    logic [4:0]         q_max_msgs;
    logic [3:0]         q_max_bytes;

    msg_result_t pending_results [$];
    int          mismatch_count;
    int          results_seen;
    int          requests_sent;
    int          reg_writes;
    int          cycle_count;
    int          burst_left;
    int          ready_left;
    logic        ready_level;
    int          outcome_tally [5];

    step_row_t opening_steps [N_OPENING] = '{
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_RECV, 8'd8, 3'd0, 1'b1, ST_AGAIN, 5'd0, '1},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_SEND, 8'd3, 3'd0, 1'b1, ST_OK, 5'd1, '1},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_SEND, 8'd8, 3'd7, 1'b0, ST_OK, 5'd0,
          64'h0123456789ABCDEF},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_SEND, 8'd9, 3'd7, 1'b1, ST_SIZE, 5'd2,
          64'hA5A5A5A5A5A5A5A5},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_SEND, 8'd255, 3'd4, 1'b1, ST_SIZE, 5'd2, '1},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_SEND, 8'd0, 3'd7, 1'b0, ST_OK, 5'd0,
          64'hDEADBEEFCAFEF00D},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_SEND, 8'd5, 3'd3, 1'b0, ST_OK, 5'd0,
          64'h8877665544332211},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_RECV, 8'd7, 3'd0, 1'b1, ST_SIZE, 5'd4, '0},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_RECV, 8'd255, 3'd0, 1'b0, ST_OK, 5'd0, '1},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_RECV, 8'd8, 3'd5, 1'b0, ST_OK, 5'd0, '0},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_RECV, 8'd8, 3'd0, 1'b0, ST_OK, 5'd0, '0},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_RECV, 8'd8, 3'd0, 1'b0, ST_OK, 5'd0, '0},
        '{ROW_CFG, CFG_NONBLOCK, 5'd0, CMD_SEND, 8'd0, 3'd0, 1'b0, ST_OK, 5'd0, '0},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_RECV, 8'd8, 3'd0, 1'b1, ST_BLOCK, 5'd0, '0},
        '{ROW_CFG, CFG_ACCESS, 5'(ACC_RDONLY), CMD_SEND, 8'd0, 3'd0, 1'b0, ST_OK, 5'd0, '0},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_SEND, 8'd1, 3'd1, 1'b1, ST_BADF, 5'd0, '1},
        '{ROW_CFG, CFG_ACCESS, 5'(ACC_WRONLY), CMD_SEND, 8'd0, 3'd0, 1'b0, ST_OK, 5'd0, '0},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_RECV, 8'd8, 3'd0, 1'b1, ST_BADF, 5'd0, '0},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_SEND, 8'd8, 3'd5, 1'b0, ST_OK, 5'd0,
          64'hFEDCBA9876543210},
        '{ROW_CFG, CFG_ACCESS, 5'(ACC_RDWR_ALT), CMD_SEND, 8'd0, 3'd0, 1'b0, ST_OK, 5'd0, '0},
        '{ROW_CFG, CFG_MAX_BYTES, 5'd0, CMD_SEND, 8'd0, 3'd0, 1'b0, ST_OK, 5'd0, '0},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_SEND, 8'd1, 3'd2, 1'b1, ST_SIZE, 5'd1, '1},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_SEND, 8'd0, 3'd2, 1'b0, ST_OK, 5'd0, '1},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_RECV, 8'd0, 3'd0, 1'b0, ST_OK, 5'd0, '0},
        '{ROW_CFG, CFG_MAX_BYTES, 5'd15, CMD_SEND, 8'd0, 3'd0, 1'b0, ST_OK, 5'd0, '0},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_SEND, 8'd9, 3'd6, 1'b1, ST_SIZE, 5'd1, '1},
        '{ROW_CFG, CFG_MAX_MSGS, 5'd1, CMD_SEND, 8'd0, 3'd0, 1'b0, ST_OK, 5'd0, '0},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_SEND, 8'd2, 3'd6, 1'b1, ST_BLOCK, 5'd1, '1},
        '{ROW_CFG, CFG_MAX_MSGS, 5'd0, CMD_SEND, 8'd0, 3'd0, 1'b0, ST_OK, 5'd0, '0},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_RECV, 8'd8, 3'd0, 1'b0, ST_OK, 5'd0, '0},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_SEND, 8'd1, 3'd1, 1'b1, ST_BLOCK, 5'd0, '1},
        '{ROW_CFG, CFG_MAX_MSGS, 5'd31, CMD_SEND, 8'd0, 3'd0, 1'b0, ST_OK, 5'd0, '0},
        '{ROW_CFG, CFG_NONBLOCK, 5'd1, CMD_SEND, 8'd0, 3'd0, 1'b0, ST_OK, 5'd0, '0},
        '{ROW_CFG, CFG_MAX_BYTES, 5'd8, CMD_SEND, 8'd0, 3'd0, 1'b0, ST_OK, 5'd0, '0},
        '{ROW_CFG, CFG_ACCESS, 5'(ACC_RDWR), CMD_SEND, 8'd0, 3'd0, 1'b0, ST_OK, 5'd0, '0},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_SEND, 8'd4, 3'd6, 1'b0, ST_OK, 5'd0,
          64'h0F1E2D3C4B5A6978},
        '{ROW_REQ, CFG_ACCESS, 5'd0, CMD_RECV, 8'd8, 3'd0, 1'b0, ST_OK, 5'd0, '0}
    };

    priority_message_queue u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] d,
                                                     input logic [LEN_W-1:0] n);
        if (n >= PAYLOAD_BYTES) begin
            return d;
        end
        return d & ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    task automatic reset_queue_model();
        for (int s = 0; s < DEPTH; s++) begin
            slot_payload[s] = '0;
            slot_len[s]     = '0;
            slot_next[s]    = SLOT_W'((s + 1) % DEPTH);
        end
        for (int l = 0; l < LEVELS; l++) begin
            lvl_head[l] = '0;
            lvl_tail[l] = '0;
        end
        lvl_busy    = '0;
        free_slot   = '0;
        held        = 0;
        q_access    = ACC_RDWR;
        q_nonblock  = 1'b1;
        q_max_msgs  = 5'd16;
        q_max_bytes = 4'd8;
    endtask

    function automatic msg_result_t apply_request(input t_op op, input logic [DATA_W-1:0] pl,
                                                  input logic [REQ_LEN_W-1:0] ln,
                                                  input logic [PRIO_W-1:0] pr);
        msg_result_t       r;
        int unsigned       limit;
        int unsigned       room;
        logic              rd_ok;
        logic              wr_ok;
        t_status           busy;
        logic [SLOT_W-1:0] slot;
        int                lvl;
        r     = '0;
        limit = (q_max_bytes > PAYLOAD_BYTES) ? PAYLOAD_BYTES : 32'(q_max_bytes);
        room  = (q_max_msgs > DEPTH) ? DEPTH : 32'(q_max_msgs);
        rd_ok = (q_access == ACC_RDONLY) || q_access[1];
        wr_ok = (q_access == ACC_WRONLY) || q_access[1];
        busy  = q_nonblock ? ST_AGAIN : ST_BLOCK;
        if (op == CMD_SEND) begin
            if (!wr_ok) begin
                r.status = ST_BADF;
            end else if (ln > limit) begin
                r.status = ST_SIZE;
            end else if (held >= room) begin
                r.status = busy;
            end else begin
                slot               = free_slot;
                free_slot          = slot_next[slot];
                slot_payload[slot] = keep_bytes(pl, ln[LEN_W-1:0]);
                slot_len[slot]     = ln[LEN_W-1:0];
                if (lvl_busy[pr]) begin
                    slot_next[lvl_tail[pr]] = slot;
                    lvl_tail[pr]            = slot;
                end else begin
                    lvl_head[pr] = slot;
                    lvl_tail[pr] = slot;
                    lvl_busy[pr] = 1'b1;
                end
                held++;
                r.wake = 1'b1;
            end
        end else begin
            if (!rd_ok) begin
                r.status = ST_BADF;
            end else if (ln < limit) begin
                r.status = ST_SIZE;
            end else if (held == 0 || lvl_busy == '0) begin
                r.status = busy;
            end else begin
                lvl = LEVELS - 1;
                while (lvl > 0 && !lvl_busy[lvl]) lvl--;
                slot = lvl_head[lvl];
                if (slot == lvl_tail[lvl]) begin
                    lvl_busy[lvl] = 1'b0;
                end else begin
                    lvl_head[lvl] = slot_next[slot];
                end
                r.len           = slot_len[slot];
                r.data          = keep_bytes(slot_payload[slot], slot_len[slot]);
                r.prio          = PRIO_W'(lvl);
                slot_next[slot] = free_slot;
                free_slot       = slot;
                held--;
                r.wake = 1'b1;
            end
        end
        r.count = CNT_W'(held);
        return r;
    endfunction

    task automatic stop_sending();
        if (burst_left != 0) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
        end
    endtask

    task automatic issue_request(input t_op op, input logic [DATA_W-1:0] pl,
                                 input logic [REQ_LEN_W-1:0] ln, input logic [PRIO_W-1:0] pr,
                                 input logic typed, input msg_result_t typed_result);
        msg_result_t r;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, pr, ln, pl};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
        end
        r = apply_request(op, pl, ln, pr);
        if (typed) begin
            r = typed_result;
        end
        outcome_tally[int'(r.status)]++;
        requests_sent++;
        pending_results.push_back(r);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        stop_sending();
        do @(posedge i_clk); while (pending_results.size() != 0);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ACCESS:    q_access    = val[1:0];
            CFG_NONBLOCK:  q_nonblock  = val[0];
            CFG_MAX_MSGS:  q_max_msgs  = val[4:0];
            CFG_MAX_BYTES: q_max_bytes = val[3:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
            end
        end
    endtask

    // receiver stall pattern
    initial begin
        ready_level = 1'b0;
        ready_left  = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (ready_left == 0) begin
                ready_level = !ready_level;
                if (ready_level) begin
                    ready_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(1, 10);
                end else begin
                    ready_left = $urandom_range(1, 6);
                end
            end
            ready_left--;
            m_axis_tready <= ready_level;
        end
    end

    always @(posedge i_clk) begin : result_check
        msg_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("result %0d arrived with nothing expected: %h",
                             results_seen, m_axis_tdata);
                end
            end else begin
                want = pending_results.pop_front();
                check_field("status", 64'(want.status), 64'(m_axis_tdata[2:0]));
                check_field("data_out", want.data, m_axis_tdata[66:3]);
                check_field("length_out", 64'(want.len), 64'(m_axis_tdata[70:67]));
                check_field("priority_out", 64'(want.prio), 64'(m_axis_tdata[73:71]));
                check_field("wake_peer", 64'(want.wake), 64'(m_axis_tdata[74]));
                check_field("message_count", 64'(want.count), 64'(m_axis_tdata[79:75]));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[priority_message_queue] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        msg_result_t          typed_result;
        step_row_t            row;
        t_op                  op;
        logic [REQ_LEN_W-1:0] ln;
        logic [PRIO_W-1:0]    pr;
        int unsigned          limit;
        int unsigned          send_pct;
        int                   pick;
        logic                 narrow;
        logic                 malformed;
        mismatch_count = 0;
        results_seen   = 0;
        requests_sent  = 0;
        reg_writes     = 0;
        cycle_count    = 0;
        burst_left     = 0;
        foreach (outcome_tally[k]) outcome_tally[k] = 0;
        reset_queue_model();
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_steps[k]) begin
            row = opening_steps[k];
            if (row.kind == ROW_CFG) begin
                write_register(row.reg_idx, row.reg_val);
            end else begin
                typed_result        = '0;
                typed_result.status = row.want_status;
                typed_result.wake   = (row.want_status == ST_OK);
                typed_result.count  = row.want_count;
                issue_request(row.op, row.payload, row.len, row.prio, row.typed, typed_result);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            pick = $urandom_range(0, 9);
            write_register(CFG_ACCESS, (pick == 0) ? 5'(ACC_RDONLY) :
                                       (pick == 1) ? 5'(ACC_WRONLY) :
                                       (pick < 6)  ? 5'(ACC_RDWR) : 5'(ACC_RDWR_ALT));
            write_register(CFG_NONBLOCK, 5'($urandom_range(0, 1)));
            pick = $urandom_range(0, 7);
            write_register(CFG_MAX_MSGS, (pick == 0) ? 5'd0 : (pick == 1) ? 5'd1 :
                                         (pick == 2) ? 5'd31 : (pick == 4) ? 5'd16 :
                                         (pick == 3) ? 5'($urandom_range(17, 31)) :
                                                       5'($urandom_range(2, 16)));
            pick = $urandom_range(0, 5);
            write_register(CFG_MAX_BYTES, (pick == 0) ? 5'd0 : (pick == 1) ? 5'd15 :
                                          (pick == 2) ? 5'($urandom_range(9, 14)) :
                                                        5'($urandom_range(1, 8)));
            narrow   = ($urandom_range(0, 2) == 0);
            send_pct = 50;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // swing between filling and draining the pool
                if (n % 32 == 0) begin
                    send_pct = 20 + 20 * $urandom_range(0, 3);
                end
                limit     = (q_max_bytes > PAYLOAD_BYTES) ? PAYLOAD_BYTES : 32'(q_max_bytes);
                malformed = ($urandom_range(0, 9) == 0);
                if ($urandom_range(1, 100) <= send_pct) begin
                    op = CMD_SEND;
                    ln = malformed ? REQ_LEN_W'($urandom_range(limit + 1, 255))
                                   : REQ_LEN_W'($urandom_range(0, limit));
                end else begin
                    op = CMD_RECV;
                    if (malformed && limit > 0) begin
                        ln = REQ_LEN_W'($urandom_range(0, limit - 1));
                    end else if ($urandom_range(0, 3) == 0) begin
                        ln = REQ_LEN_W'($urandom_range(limit, 255));
                    end else begin
                        ln = REQ_LEN_W'($urandom_range(limit, PAYLOAD_BYTES));
                    end
                end
                if (narrow) begin
                    pr = $urandom_range(0, 1) ? PRIO_W'(LEVELS - 1) : PRIO_W'(0);
                end else begin
                    pr = PRIO_W'($urandom_range(0, LEVELS - 1));
                end
                issue_request(op, {$urandom, $urandom}, ln, pr, 1'b0, '0);
            end
        end

        stop_sending();
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (10) @(posedge i_clk);

        $display("run covered %0d requests (%0d results) over %0d register writes",
                 requests_sent, results_seen, reg_writes);
        $display("outcomes: ok %0d, bad access %0d, size %0d, again %0d, would block %0d",
                 outcome_tally[0], outcome_tally[1], outcome_tally[2], outcome_tally[3],
                 outcome_tally[4]);
        if (mismatch_count == 0) begin
            $display("[priority_message_queue] OK");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("[priority_message_queue] ERROR");
        end
        $finish;
    end

endmodule
